@@ rtl/json_token_lexer_assert.svh @@
// Assertion macros for the JSON token lexer.
// Used by the top level; relies on signals clk and rst_n being in scope.
`ifndef JSON_TOKEN_LEXER_ASSERT_SVH
`define JSON_TOKEN_LEXER_ASSERT_SVH

// Condition must never hold outside reset.
`define JTL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent at one edge forces the consequent at the next edge.
`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jtl_pkg.sv @@
// Shared types, constants and keyword tables for the JSON token lexer.
// No dependencies; imported by every lexer module.
`default_nettype none

package jtl_pkg;

    // Widths
    localparam int OFFSET_W    = 32;
    localparam int START_W     = 32;
    localparam int KIND_W      = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - START_W - 10;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int SLOT_N      = 12;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_COLON    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LBRACKET = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RBRACKET = 4'd5;
    localparam logic [KIND_W-1:0] KIND_BOOL     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NULL     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_STRING   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EOF      = 4'd11;

    // Keyword ids
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;
    localparam logic [1:0] KW_NONE  = 2'd3;

    // Characters
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_E_LO     = 8'h65;
    localparam logic [7:0] CH_E_UP     = 8'h45;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_S        = 8'h73;

    // One result item, offset kept at full width until output
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] start;
        logic [7:0]          ch;
        logic                present;
        logic                done;
    } res_t;

    // Work for one input item, in emission order:
    // keyword flush, two results, end-of-input flush, one result, EOF
    typedef struct packed {
        logic [2:0]          f1_n;
        logic [1:0]          f1_kw;
        logic [OFFSET_W-1:0] f1_start;
        logic                r1_v;
        res_t                r1;
        logic                r2_v;
        res_t                r2;
        logic [2:0]          f2_n;
        logic [1:0]          f2_kw;
        logic [OFFSET_W-1:0] f2_start;
        logic                r3_v;
        res_t                r3;
        logic                eof_v;
        logic [OFFSET_W-1:0] eof_start;
    } cmd_t;

    function automatic res_t make_res(input logic [KIND_W-1:0] kind,
                                      input logic [OFFSET_W-1:0] start,
                                      input logic [7:0] ch,
                                      input logic present,
                                      input logic done);
        res_t r;
        r.kind    = kind;
        r.start   = start;
        r.ch      = present ? ch : 8'h00;
        r.present = present;
        r.done    = done;
        return r;
    endfunction

    // Keyword text, indexed by keyword id and byte position
    function automatic logic [7:0] kw_char(input logic [1:0] kid, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (kid)
            KW_TRUE:
            begin
                unique case (idx)
                    3'd0:    c = CH_T;
                    3'd1:    c = CH_R;
                    3'd2:    c = CH_U;
                    3'd3:    c = CH_E_LO;
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE:
            begin
                unique case (idx)
                    3'd0:    c = CH_F;
                    3'd1:    c = CH_A;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_S;
                    3'd4:    c = CH_E_LO;
                    default: c = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                unique case (idx)
                    3'd0:    c = CH_N;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_L;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kid);
        logic [2:0] n;
        unique case (kid)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/json_token_lexer.sv @@
// JSON token lexer, one text byte per input item, zero or more token items out.
// A byte whose input item shows no result pushes no command; a byte that yields
// n result items (at most seven, e.g. a broken keyword prefix followed by a
// number at end of input) holds the output port until all n are sent, since the
// emitter sends one result item per cycle while the output is ready. The front
// end lexes one byte per cycle while the queue has room and hands a command to
// a two-entry queue; the emitter expands it, so the sustained rate is one byte
// per cycle as long as bytes average at most one result each.
// Input tdata: text_byte; tlast marks end of input. Output tuser: token_kind;
// tlast marks the last result of one input byte.
`default_nettype none

`include "json_token_lexer_assert.svh"

module json_token_lexer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [jtl_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] text_byte
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [31:0] token_start, [39:32] value_char, [40] value_present,
    // [41] token_done, upper bits zero
    output logic [jtl_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic                                      m_tlast,
    output logic [jtl_pkg::KIND_W-1:0]                m_tuser    // [3:0] token_kind
);
    import jtl_pkg::*;

    cmd_t push_cmd;
    cmd_t q_head;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    res_t out_res;

    jtl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    jtl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    jtl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    // Output packing
    assign m_tuser = out_res.kind;
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.done, out_res.present, out_res.ch,
                      START_W'(out_res.start)};

    // Queue never overflows or underflows
    `JTL_ASSERT_NEVER(a_no_overflow, q_push && q_full, "command pushed into full queue")
    `JTL_ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "command popped from empty queue")
    // End of input always leaves a command (at least the EOF) queued
    `JTL_ASSERT_NEXT(a_eof_queued, s_tvalid && s_tready && s_tlast, !q_empty,
                     "end of input produced no command")

endmodule

`default_nettype wire

@@ rtl/jtl_front.sv @@
// Front end of the JSON token lexer: accepts text bytes, runs the lexer
// state machine and turns each byte into at most one work command. Uses jtl_pkg.
`default_nettype none

module jtl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire logic          q_full,
    output logic               push,
    output jtl_pkg::cmd_t      cmd
);
    import jtl_pkg::*;

    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_KEYWORD  = 3'd1;
    localparam logic [2:0] MODE_STRING   = 3'd2;
    localparam logic [2:0] MODE_STR_ESC  = 3'd3;
    localparam logic [2:0] MODE_NUM_INT  = 3'd4;
    localparam logic [2:0] MODE_NUM_FRAC = 3'd5;
    localparam logic [2:0] MODE_NUM_EXP  = 3'd6;
    localparam logic [2:0] MODE_NUM_EXPD = 3'd7;

    typedef struct packed {
        logic       rv;
        res_t       r;
        logic [2:0] mode;
        logic [1:0] kid;
        logic [2:0] km;
        logic       set_start;
    } idle_t;

    logic [2:0]          mode_reg, mode_next;
    logic [1:0]          kid_reg, kid_next;
    logic [2:0]          km_reg, km_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [OFFSET_W-1:0] tstart_reg, tstart_next;

    logic [2:0]          km_inc;
    logic [2:0]          num_mode;
    logic                do_idle;
    idle_t               idle_r;
    logic [OFFSET_W-1:0] off_inc;
    logic                accept;
    logic                has_out;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Lexing of a byte that starts a fresh token
    function automatic idle_t lex_idle(input logic [7:0] c,
                                       input logic [OFFSET_W-1:0] off,
                                       input logic [1:0] kid);
        idle_t o;
        o = '0;
        o.mode = MODE_IDLE;
        o.kid  = kid;
        priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
        begin
            o.rv = 1'b0;
        end
        else if (c == CH_LBRACE)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_LBRACE, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_RBRACE)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_RBRACE, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_COMMA)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_COMMA, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_COLON)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_COLON, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_LBRACKET)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_LBRACKET, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_RBRACKET)
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_RBRACKET, off, 8'h00, 1'b0, 1'b1);
        end
        else if (c == CH_T || c == CH_F || c == CH_N)
        begin
            o.kid       = (c == CH_T) ? KW_TRUE : ((c == CH_F) ? KW_FALSE : KW_NULL);
            o.km        = 3'd1;
            o.set_start = 1'b1;
            o.mode      = MODE_KEYWORD;
        end
        else if (c == CH_QUOTE)
        begin
            o.set_start = 1'b1;
            o.mode      = MODE_STRING;
        end
        else if (is_digit(c) || c == CH_MINUS)
        begin
            o.set_start = 1'b1;
            o.rv        = 1'b1;
            o.r         = make_res(KIND_NUMBER, off, c, 1'b1, 1'b0);
            o.mode      = MODE_NUM_INT;
        end
        else
        begin
            o.rv = 1'b1;
            o.r  = make_res(KIND_INVALID, off, c, 1'b1, 1'b1);
        end
        return o;
    endfunction

    // Number sub-state after one more byte; idle means the number ended
    function automatic logic [2:0] number_next(input logic [2:0] mode, input logic [7:0] c);
        logic       dig;
        logic       expc;
        logic [2:0] nm;
        dig  = is_digit(c);
        expc = (c == CH_E_LO) || (c == CH_E_UP);
        nm   = MODE_IDLE;
        unique case (mode)
            MODE_NUM_INT:
            begin
                priority if (dig)       nm = MODE_NUM_INT;
                else if (c == CH_DOT)   nm = MODE_NUM_FRAC;
                else if (expc)          nm = MODE_NUM_EXP;
                else                    nm = MODE_IDLE;
            end
            MODE_NUM_FRAC:
            begin
                priority if (dig)       nm = MODE_NUM_FRAC;
                else if (expc)          nm = MODE_NUM_EXP;
                else                    nm = MODE_IDLE;
            end
            MODE_NUM_EXP:
            begin
                nm = (dig || c == CH_PLUS || c == CH_MINUS) ? MODE_NUM_EXPD : MODE_IDLE;
            end
            default:
            begin
                nm = dig ? MODE_NUM_EXPD : MODE_IDLE;
            end
        endcase
        return nm;
    endfunction

    // Lexer step for the current byte
    always_comb
    begin
        cmd         = '0;
        mode_next   = mode_reg;
        kid_next    = kid_reg;
        km_next     = km_reg;
        tstart_next = tstart_reg;
        do_idle     = 1'b0;
        km_inc      = 3'(km_reg + 3'd1);
        num_mode    = number_next(mode_reg, in_byte);

        unique case (mode_reg)
            MODE_KEYWORD:
            begin
                if (km_reg < kw_len(kid_reg) && in_byte == kw_char(kid_reg, km_reg))
                begin
                    if (km_inc >= kw_len(kid_reg))
                    begin
                        cmd.r1_v = 1'b1;
                        if (kid_reg == KW_NULL)
                            cmd.r1 = make_res(KIND_NULL, tstart_reg, 8'h00, 1'b0, 1'b1);
                        else
                            cmd.r1 = make_res(KIND_BOOL, tstart_reg,
                                              kw_char(kid_reg, 3'd0), 1'b1, 1'b1);
                        mode_next = MODE_IDLE;
                        km_next   = 3'd0;
                    end
                    else
                    begin
                        km_next = km_inc;
                    end
                end
                else
                begin
                    // prefix broke off: one invalid item per byte seen
                    cmd.f1_n     = km_reg;
                    cmd.f1_kw    = kid_reg;
                    cmd.f1_start = tstart_reg;
                    do_idle      = 1'b1;
                end
            end
            MODE_STRING:
            begin
                priority if (in_byte == CH_QUOTE)
                begin
                    cmd.r1_v  = 1'b1;
                    cmd.r1    = make_res(KIND_STRING, tstart_reg, 8'h00, 1'b0, 1'b1);
                    mode_next = MODE_IDLE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_STR_ESC;
                end
                else
                begin
                    cmd.r1_v = 1'b1;
                    cmd.r1   = make_res(KIND_STRING, tstart_reg, in_byte, 1'b1, 1'b0);
                end
            end
            MODE_STR_ESC:
            begin
                cmd.r1_v  = 1'b1;
                cmd.r1    = make_res(KIND_STRING, tstart_reg, in_byte, 1'b1, 1'b0);
                mode_next = MODE_STRING;
            end
            MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXP, MODE_NUM_EXPD:
            begin
                cmd.r1_v = 1'b1;
                if (num_mode != MODE_IDLE)
                begin
                    cmd.r1    = make_res(KIND_NUMBER, tstart_reg, in_byte, 1'b1, 1'b0);
                    mode_next = num_mode;
                end
                else
                begin
                    // number ends; its terminator is lexed again
                    cmd.r1  = make_res(KIND_NUMBER, tstart_reg, 8'h00, 1'b0, 1'b1);
                    do_idle = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        idle_r = lex_idle(in_byte, off_reg, kid_reg);
        if (do_idle)
        begin
            cmd.r2_v  = idle_r.rv;
            cmd.r2    = idle_r.r;
            mode_next = idle_r.mode;
            kid_next  = idle_r.kid;
            km_next   = idle_r.km;
            if (idle_r.set_start)
                tstart_next = off_reg;
        end

        off_inc  = off_reg + OFFSET_W'(1);
        off_next = off_inc;

        // end of input: flush what is pending, then EOF
        if (in_last)
        begin
            unique case (mode_next)
                MODE_KEYWORD:
                begin
                    cmd.f2_n     = km_next;
                    cmd.f2_kw    = kid_next;
                    cmd.f2_start = tstart_next;
                end
                MODE_STRING, MODE_STR_ESC:
                begin
                    cmd.r3_v = 1'b1;
                    cmd.r3   = make_res(KIND_INVALID, tstart_next, 8'h00, 1'b0, 1'b1);
                end
                MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXP, MODE_NUM_EXPD:
                begin
                    cmd.r3_v = 1'b1;
                    cmd.r3   = make_res(KIND_NUMBER, tstart_next, 8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                    cmd.r3_v = 1'b0;
                end
            endcase
            cmd.eof_v     = 1'b1;
            cmd.eof_start = off_inc;
            mode_next     = MODE_IDLE;
            kid_next      = KW_TRUE;
            km_next       = 3'd0;
            off_next      = '0;
        end
    end

    // Handshake toward the command queue
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign has_out  = (cmd.f1_n != 3'd0) || cmd.r1_v || cmd.r2_v ||
                      (cmd.f2_n != 3'd0) || cmd.r3_v || cmd.eof_v;
    assign push     = accept && has_out;

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            kid_reg    <= KW_TRUE;
            km_reg     <= 3'd0;
            off_reg    <= '0;
            tstart_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            kid_reg    <= kid_next;
            km_reg     <= km_next;
            off_reg    <= off_next;
            tstart_reg <= tstart_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jtl_queue.sv @@
// Short command queue between the lexer front end and the emitter.
// Register-based FIFO of cmd_t entries; uses jtl_pkg.
`default_nettype none

module jtl_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jtl_pkg::cmd_t push_data,
    input  wire logic          pop,
    output jtl_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);
    import jtl_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/jtl_back.sv @@
// Emitter of the JSON token lexer: expands one command into its result items,
// one per cycle when not stalled, into a registered output stage. Uses jtl_pkg.
`default_nettype none

module jtl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jtl_pkg::cmd_t q_head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output jtl_pkg::res_t      out_res,
    output logic               out_last
);
    import jtl_pkg::*;

    // Slot positions inside the pending mask
    localparam logic [3:0] SLOT_F1  = 4'd0;
    localparam logic [3:0] SLOT_R1  = 4'd4;
    localparam logic [3:0] SLOT_R2  = 4'd5;
    localparam logic [3:0] SLOT_F2  = 4'd6;
    localparam logic [3:0] SLOT_R3  = 4'd10;
    localparam logic [3:0] SLOT_EOF = 4'd11;

    cmd_t              cmd_reg;
    logic [SLOT_N-1:0] mask_reg, mask_next;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              out_last_reg;

    logic [SLOT_N-1:0] rest;
    logic [SLOT_N-1:0] head_mask;
    logic [3:0]        sel;
    logic              emit;
    logic              can_load;
    res_t              sel_res;

    function automatic res_t flush_res(input logic [1:0] kid,
                                       input logic [OFFSET_W-1:0] start,
                                       input logic [1:0] idx);
        return make_res(KIND_INVALID, start + OFFSET_W'(idx),
                        kw_char(kid, {1'b0, idx}), 1'b1, 1'b1);
    endfunction

    // Pending slots of the command at the queue head
    always_comb
    begin
        head_mask = '0;
        for (int i = 0; i < 4; i++)
        begin
            head_mask[int'(SLOT_F1) + i] = (q_head.f1_n > 3'(i));
            head_mask[int'(SLOT_F2) + i] = (q_head.f2_n > 3'(i));
        end
        head_mask[SLOT_R1]  = q_head.r1_v;
        head_mask[SLOT_R2]  = q_head.r2_v;
        head_mask[SLOT_R3]  = q_head.r3_v;
        head_mask[SLOT_EOF] = q_head.eof_v;
    end

    // Lowest pending slot goes out first
    always_comb
    begin
        sel = SLOT_F1;
        for (int i = SLOT_N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = 4'(i);
        end
    end

    always_comb
    begin
        priority if (sel < SLOT_R1)
            sel_res = flush_res(cmd_reg.f1_kw, cmd_reg.f1_start, sel[1:0]);
        else if (sel == SLOT_R1)
            sel_res = cmd_reg.r1;
        else if (sel == SLOT_R2)
            sel_res = cmd_reg.r2;
        else if (sel < SLOT_R3)
            sel_res = flush_res(cmd_reg.f2_kw, cmd_reg.f2_start, 2'(sel - SLOT_F2));
        else if (sel == SLOT_R3)
            sel_res = cmd_reg.r3;
        else
            sel_res = make_res(KIND_EOF, cmd_reg.eof_start, 8'h00, 1'b0, 1'b1);
    end

    // Emit and reload control
    assign rest     = mask_reg & (mask_reg - 1'b1);
    assign emit     = (mask_reg != '0) && (!out_valid_reg || out_ready);
    assign can_load = (mask_reg == '0) || (emit && rest == '0);
    assign q_pop    = can_load && !q_empty;

    always_comb
    begin
        priority if (q_pop)
            mask_next = head_mask;
        else if (emit)
            mask_next = rest;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Command and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_head;
        if (emit)
        begin
            out_res_reg  <= sel_res;
            out_last_reg <= (rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

@@ bench/json_token_checker.sv @@
// Scoreboard for the JSON token lexer: predicts the token items of every
// accepted text byte and compares them with the output stream.
// Depends on jtl_pkg for widths, token kinds, keyword ids and characters.
`default_nettype none

module json_token_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [jtl_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] text_byte
    input  wire logic                           s_tlast,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] token_start, [39:32] value_char, [40] value_present, [41] token_done
    input  wire logic [jtl_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                           m_tlast,
    input  wire logic [jtl_pkg::KIND_W-1:0]     m_tuser,   // [3:0] token_kind
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  checked_count
);

    import jtl_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_KEYWORD,
        LX_STRING,
        LX_ESCAPE,
        LX_INT,
        LX_FRAC,
        LX_EXP,
        LX_EXP_DIGITS
    } lex_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [7:0]         ch;
        logic               present;
        logic               done;
        logic               last;
    } token_item_t;

    // Lexer state mirrored from the byte stream
    lex_state_t          lx_state;
    logic [1:0]          kw_id;
    logic [2:0]          kw_seen;
    logic [OFFSET_W-1:0] next_offset;
    logic [OFFSET_W-1:0] tok_start;

    // Predicted token items, oldest first
    token_item_t token_q[$];

    // Letters of true, false and null, first letter in the low byte
    function automatic logic [7:0] keyword_letter(input logic [1:0] id, input logic [2:0] pos);
        logic [39:0] word;
        case (id)
            KW_TRUE:  word = {8'h00, CH_E_LO, CH_U, CH_R, CH_T};
            KW_FALSE: word = {CH_E_LO, CH_S, CH_L, CH_A, CH_F};
            KW_NULL:  word = {8'h00, CH_L, CH_L, CH_U, CH_N};
            default:  word = '0;
        endcase
        return (pos < 3'd5) ? word[pos*8 +: 8] : 8'h00;
    endfunction

    // Number grammar: where the next byte takes a number, or idle if it ends it
    function automatic lex_state_t number_step(input lex_state_t st, input logic [7:0] c);
        logic       digit;
        logic       exp_mark;
        lex_state_t nxt;
        digit    = (c >= CH_ZERO) && (c <= CH_NINE);
        exp_mark = (c == CH_E_LO) || (c == CH_E_UP);
        nxt      = LX_IDLE;
        case (st)
            LX_INT:
            begin
                if (digit)
                    nxt = LX_INT;
                else if (c == CH_DOT)
                    nxt = LX_FRAC;
                else if (exp_mark)
                    nxt = LX_EXP;
            end
            LX_FRAC:
            begin
                if (digit)
                    nxt = LX_FRAC;
                else if (exp_mark)
                    nxt = LX_EXP;
            end
            LX_EXP:
            begin
                if (digit || (c == CH_PLUS) || (c == CH_MINUS))
                    nxt = LX_EXP_DIGITS;
            end
            default:
            begin
                if (digit)
                    nxt = LX_EXP_DIGITS;
            end
        endcase
        return nxt;
    endfunction

    task automatic add_token(input logic [KIND_W-1:0] kind, input logic [OFFSET_W-1:0] start,
                             input logic [7:0] ch, input logic present, input logic done);
        token_item_t t;
        t.kind    = kind;
        t.start   = start[START_W-1:0];
        t.ch      = present ? ch : 8'h00;
        t.present = present;
        t.done    = done;
        t.last    = 1'b0;
        token_q.insert(token_q.size(), t);
    endtask

    // Broken keyword: every letter seen so far becomes an invalid token
    task automatic flush_prefix();
        for (int i = 0; (i < kw_seen) && (i < 5); i++)
            add_token(KIND_INVALID, tok_start + i, keyword_letter(kw_id, i[2:0]), 1'b1, 1'b1);
        lx_state = LX_IDLE;
        kw_seen  = 3'd0;
    endtask

    // A byte seen between tokens
    task automatic lex_fresh(input logic [7:0] c, input logic [OFFSET_W-1:0] off);
        lx_state = LX_IDLE;
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: ;   // skipped
            CH_LBRACE:   add_token(KIND_LBRACE, off, 8'h00, 1'b0, 1'b1);
            CH_RBRACE:   add_token(KIND_RBRACE, off, 8'h00, 1'b0, 1'b1);
            CH_COMMA:    add_token(KIND_COMMA, off, 8'h00, 1'b0, 1'b1);
            CH_COLON:    add_token(KIND_COLON, off, 8'h00, 1'b0, 1'b1);
            CH_LBRACKET: add_token(KIND_LBRACKET, off, 8'h00, 1'b0, 1'b1);
            CH_RBRACKET: add_token(KIND_RBRACKET, off, 8'h00, 1'b0, 1'b1);
            CH_T, CH_F, CH_N:
            begin
                kw_id     = (c == CH_T) ? KW_TRUE : ((c == CH_F) ? KW_FALSE : KW_NULL);
                kw_seen   = 3'd1;
                tok_start = off;
                lx_state  = LX_KEYWORD;
            end
            CH_QUOTE:
            begin
                tok_start = off;
                lx_state  = LX_STRING;
            end
            default:
            begin
                if (((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_MINUS))
                begin
                    tok_start = off;
                    add_token(KIND_NUMBER, off, c, 1'b1, 1'b0);
                    lx_state = LX_INT;
                end
                else
                    add_token(KIND_INVALID, off, c, 1'b1, 1'b1);
            end
        endcase
    endtask

    // All token items caused by one text byte
    task automatic predict_byte(input logic [7:0] c, input logic eoi);
        logic [OFFSET_W-1:0] off;
        lex_state_t          nxt;
        logic [2:0]          kw_len_now;
        int                  mark;
        token_item_t         tail;
        off  = next_offset;
        mark = token_q.size();
        case (lx_state)
            LX_KEYWORD:
            begin
                kw_len_now = (kw_id == KW_FALSE) ? 3'd5 : 3'd4;
                if ((kw_seen < kw_len_now) && (c == keyword_letter(kw_id, kw_seen)))
                begin
                    kw_seen = kw_seen + 3'd1;
                    if (kw_seen >= kw_len_now)
                    begin
                        if (kw_id == KW_NULL)
                            add_token(KIND_NULL, tok_start, 8'h00, 1'b0, 1'b1);
                        else
                            add_token(KIND_BOOL, tok_start, keyword_letter(kw_id, 3'd0),
                                      1'b1, 1'b1);
                        lx_state = LX_IDLE;
                        kw_seen  = 3'd0;
                    end
                end
                else
                begin
                    flush_prefix();
                    lex_fresh(c, off);
                end
            end
            LX_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    add_token(KIND_STRING, tok_start, 8'h00, 1'b0, 1'b1);
                    lx_state = LX_IDLE;
                end
                else if (c == CH_BSLASH)
                    lx_state = LX_ESCAPE;
                else
                    add_token(KIND_STRING, tok_start, c, 1'b1, 1'b0);
            end
            LX_ESCAPE:
            begin
                add_token(KIND_STRING, tok_start, c, 1'b1, 1'b0);
                lx_state = LX_STRING;
            end
            LX_INT, LX_FRAC, LX_EXP, LX_EXP_DIGITS:
            begin
                nxt = number_step(lx_state, c);
                if (nxt != LX_IDLE)
                begin
                    add_token(KIND_NUMBER, tok_start, c, 1'b1, 1'b0);
                    lx_state = nxt;
                end
                else
                begin
                    // number ends; the same byte is lexed again
                    add_token(KIND_NUMBER, tok_start, 8'h00, 1'b0, 1'b1);
                    lex_fresh(c, off);
                end
            end
            default: lex_fresh(c, off);
        endcase
        next_offset = off + 1'b1;

        // End of text: flush the pending token, then EOF past the last byte
        if (eoi)
        begin
            case (lx_state)
                LX_IDLE: ;
                LX_KEYWORD: flush_prefix();
                LX_STRING, LX_ESCAPE: add_token(KIND_INVALID, tok_start, 8'h00, 1'b0, 1'b1);
                default: add_token(KIND_NUMBER, tok_start, 8'h00, 1'b0, 1'b1);
            endcase
            add_token(KIND_EOF, next_offset, 8'h00, 1'b0, 1'b1);
            lx_state    = LX_IDLE;
            kw_id       = KW_TRUE;
            kw_seen     = 3'd0;
            next_offset = '0;
        end

        if (token_q.size() > mark)
        begin
            tail                         = token_q[token_q.size() - 1];
            tail.last                    = 1'b1;
            token_q[token_q.size() - 1] = tail;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        token_item_t want;
        if (!rst_n)
        begin
            lx_state      = LX_IDLE;
            kw_id         = KW_TRUE;
            kw_seen       = 3'd0;
            next_offset   = '0;
            tok_start     = '0;
            token_q.delete();
            fail_count    = 0;
            outstanding   = 0;
            checked_count = 0;
        end
        else
        begin
            // text byte accepted: predict its tokens
            if (s_tvalid && s_tready)
                predict_byte(s_tdata[7:0], s_tlast);

            // token item accepted: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("unexpected token item: kind %0d start %0d",
                           m_tuser, m_tdata[START_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = token_q.pop_front();
                    checked_count++;
                    compare_field("token_kind", 32'(want.kind), 32'(m_tuser));
                    compare_field("token_start", want.start, m_tdata[START_W-1:0]);
                    compare_field("value_char", 32'(want.ch), 32'(m_tdata[START_W+7:START_W]));
                    compare_field("value_present", 32'(want.present), 32'(m_tdata[START_W+8]));
                    compare_field("token_done", 32'(want.done), 32'(m_tdata[START_W+9]));
                    compare_field("run_last", 32'(want.last), 32'(m_tlast));
                end
            end
            outstanding = token_q.size();
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Top of the JSON token lexer bench: clock, reset, byte stimulus and the
// verdict. Depends on jtl_pkg, json_token_lexer and json_token_checker.
`default_nettype none

module tb_top;

    import jtl_pkg::*;

    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [KIND_W-1:0]      m_tuser;

    int fail_count;
    int outstanding;
    int checked_count;

    // Text bytes to send: bit 8 marks the end of a text
    logic [8:0] text_q[$];
    int         bytes_sent;
    int         texts_ended;
    logic       text_sent;
    logic       src_calm;
    logic       sink_calm;
    logic       sink_hold;
    int         cycles;

    json_token_lexer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    json_token_checker token_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic add_byte(input logic [7:0] b, input logic end_flag);
        text_q.insert(text_q.size(), {end_flag, b});
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    // Mark the newest byte as the end of its text
    task automatic end_text();
        logic [8:0] entry;
        entry                      = text_q[text_q.size() - 1];
        entry[8]                   = 1'b1;
        text_q[text_q.size() - 1] = entry;
    endtask

    task automatic add_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            add_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    // One random piece of text, mostly well-formed tokens
    task automatic add_fragment();
        string      word;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                case ($urandom_range(0, 5))
                    0:       b = CH_LBRACE;
                    1:       b = CH_RBRACE;
                    2:       b = CH_COMMA;
                    3:       b = CH_COLON;
                    4:       b = CH_LBRACKET;
                    default: b = CH_RBRACKET;
                endcase
                add_byte(b, 1'b0);
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       b = CH_SPACE;
                    1:       b = CH_TAB;
                    2:       b = CH_CR;
                    default: b = CH_LF;
                endcase
                add_byte(b, 1'b0);
            end
            3, 4, 5:
            begin
                case ($urandom_range(0, 2))
                    0:       word = "true";
                    1:       word = "false";
                    default: word = "null";
                endcase
                // one in three keywords breaks off early
                if ($urandom_range(0, 2) == 0)
                    word = word.substr(0, $urandom_range(0, word.len() - 2));
                add_string(word);
            end
            6, 7:
            begin
                add_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            add_byte(CH_BSLASH, 1'b0);
                            add_byte(8'($urandom_range(0, 255)), 1'b0);
                        end
                        1:       add_byte(8'($urandom_range(0, 255)), 1'b0);
                        default: add_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                    endcase
                end
                // now and then the string stays open
                if ($urandom_range(0, 7) != 0)
                    add_byte(CH_QUOTE, 1'b0);
            end
            8, 9:
            begin
                if ($urandom_range(0, 2) == 0)
                    add_byte(CH_MINUS, 1'b0);
                add_digits(1, 3);
                if ($urandom_range(0, 1) == 1)
                begin
                    add_byte(CH_DOT, 1'b0);
                    add_digits(0, 3);
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    add_byte(($urandom_range(0, 1) == 1) ? CH_E_LO : CH_E_UP, 1'b0);
                    case ($urandom_range(0, 2))
                        0:       add_byte(CH_PLUS, 1'b0);
                        1:       add_byte(CH_MINUS, 1'b0);
                        default: ;
                    endcase
                    add_digits(0, 2);
                end
            end
            default: add_byte(8'($urandom_range(0, 255)), 1'b0);
        endcase
        if ($urandom_range(0, 9) == 0)
            end_text();
    endtask

    task automatic build_stimulus();
        int directed_n;
        // punctuation, null, keyword broken by a high byte, number grammar
        add_string("{}[],:null");
        add_byte(CH_T, 1'b0);
        add_byte(8'h80, 1'b0);
        add_string("-.E+5");
        // escaped quote inside a string, then the closing quote
        add_string("\"\\\"\"");
        // string left open after a backslash at end of text
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH, 1'b1);
        // keyword prefix and open number at end of text: seven token items
        add_string("fals");
        add_byte(CH_MINUS, 1'b1);
        directed_n = text_q.size();
        while (text_q.size() < directed_n + RANDOM_BYTES)
            add_fragment();
        end_text();
    endtask

    // Byte source
    initial
    begin
        int         gap;
        logic [8:0] entry;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        bytes_sent  = 0;
        texts_ended = 0;
        text_sent   = 1'b0;
        src_calm    = 1'b0;
        build_stimulus();
        @(posedge rst_n);
        @(posedge clk);
        foreach (text_q[i])
        begin
            if ($urandom_range(0, 63) == 0)
                src_calm = !src_calm;
            gap = src_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            entry = text_q[i];
            s_tvalid <= 1'b1;
            s_tdata  <= entry[7:0];
            s_tlast  <= entry[8];
            do
                @(posedge clk);
            while (!s_tready);
            bytes_sent++;
            if (entry[8])
                texts_ended++;
        end
        s_tvalid  <= 1'b0;
        text_sent = 1'b1;
    end

    // Token sink: random gap after every item, calm stretches, one long hold
    initial
    begin
        int gap;
        m_tready  <= 1'b0;
        gap       = 0;
        sink_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if ($urandom_range(0, 63) == 0)
                    sink_calm = !sink_calm;
                gap = sink_calm ? 0 : $urandom_range(0, 4);
            end
            else if (gap > 0)
                gap--;
            m_tready <= !sink_hold && (gap == 0);
        end
    end

    // Long output stall while bytes keep coming, to back up the input
    initial
    begin
        sink_hold <= 1'b0;
        wait (bytes_sent >= 120);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("timeout after %0d cycles, %0d token items still due", cycles, outstanding);
        $display("status: fail");
        $finish;
    end

    // Verdict
    initial
    begin
        wait (text_sent);
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d text bytes in %0d texts, including broken keywords, open strings",
                 bytes_sent, texts_ended);
        $display("and noise bytes; %0d token items checked, one %0d-cycle output stall",
                 checked_count, HOLD_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
